/* design/whss_pkg.sv */
// package for the weighted hash socket steering block
// shared constants and the hash prefold; no dependencies
package whss_pkg;

    localparam int NUM_SOCKETS_DEF = 8;
    localparam int TABLE_DEPTH_DEF = 128;
    localparam int HASH_W = 32;
    localparam int WEIGHT_W = 4;
    localparam int WEIGHT_REG_W = 32;
    localparam int MAX_WEIGHTED = 8;
    localparam logic [31:0] WEIGHTS_RESET = 32'h1111_1111;

    localparam logic [1:0] MODE_BCAST  = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    function automatic logic [HASH_W-1:0] mix_hash(input logic [HASH_W-1:0] h);
        mix_hash = h ^ (h >> 8) ^ (h >> 16) ^ (h >> 24);
    endfunction

endpackage

/* design/weighted_hash_socket_steering.sv */
// weighted hash socket steering, top level
// uses whss_pkg; holds the weighted table memory and a restoring divider
//
// An item is taken when i_start is high and o_busy is low; its socket mask comes
// out on o_steer_mask with o_done high for one cycle, and the receiver cannot
// stall it. Broadcast (mode 0 or 3) goes from acceptance straight to the output
// state. For each hash, a steering item with an unchanged eligible mask passes
// through the fold state, 32 steps in a bit-serial modulo unit, the wait state,
// one synchronous table read and the output state; power-of-two counts and
// in-range masked hashes skip the divider, save counts of 3, 5, 6 and 7. A
// changed mask first rebuilds the table, visiting each socket in turn and
// writing one entry per cycle, up to TABLE_DEPTH entries in all.
module weighted_hash_socket_steering #(
    parameter int NUM_SOCKETS = whss_pkg::NUM_SOCKETS_DEF,
    parameter int TABLE_DEPTH = whss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [NUM_SOCKETS-1:0] i_eligible_mask,
    input  logic [31:0]            i_hash,
    input  logic [31:0]            i_hash2,
    input  logic [1:0]             i_mode,
    output logic                   o_done,
    output logic [NUM_SOCKETS-1:0] o_steer_mask
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SOCK_W = $clog2(NUM_SOCKETS);
    localparam int SCNT_W = $clog2(NUM_SOCKETS + 1);
    localparam int USED = (NUM_SOCKETS < whss_pkg::MAX_WEIGHTED) ? NUM_SOCKETS
                                                                : whss_pkg::MAX_WEIGHTED;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SOCK  = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_FOLD  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_WAIT  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]             r_state;
    logic [31:0]            r_weights;
    logic [NUM_SOCKETS-1:0] r_cached;
    logic [CNT_W-1:0]       r_count;
    logic [NUM_SOCKETS-1:0] r_elig;
    logic [31:0]            r_h1, r_h2;
    logic                   r_dbl, r_second, r_bcast;
    logic [SCNT_W-1:0]      r_sock;
    logic [3:0]             r_wleft;
    logic [31:0]            r_a;
    logic [CNT_W-1:0]       r_rem;
    logic [5:0]             r_bit;
    logic [IDX_W-1:0]       r_idx;
    logic [NUM_SOCKETS-1:0] r_res;
    logic                   r_done;

    logic [NUM_SOCKETS-1:0] mem [TABLE_DEPTH];
    logic [NUM_SOCKETS-1:0] r_rdata;

    // memory ports
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [NUM_SOCKETS-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    // fold helpers
    logic [31:0]      mixed;
    logic [CNT_W:0]   cnt_ext;
    logic             is_pow2;
    logic             is_small;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W:0]   pmask;
    logic [CNT_W:0]   r_low;
    logic [CNT_W:0]   trial;
    logic [3:0]       cur_w;

    assign mixed   = whss_pkg::mix_hash(r_second ? r_h2 : r_h1);
    assign cnt_ext = {1'b0, r_count};
    assign cnt_m1  = r_count - 1'b1;
    assign is_pow2 = (r_count & cnt_m1) == '0;
    // counts of 3, 5, 6 and 7 always take the true modulo
    assign is_small = (r_count == CNT_W'(3)) || (r_count == CNT_W'(5))
                      || (r_count == CNT_W'(6)) || (r_count == CNT_W'(7));

    always_comb begin
        pmask = '0;
        for (int i = 0; i <= CNT_W; i++) begin
            if ((cnt_ext >> i) != '0) pmask[i] = 1'b1;
        end
    end
    assign r_low = mixed[CNT_W:0] & pmask;
    assign trial = {r_rem, r_a[31]};

    always_comb begin
        cur_w = '0;
        if (r_sock < SCNT_W'(USED)) begin
            cur_w = r_weights[r_sock[SOCK_W-1:0]*whss_pkg::WEIGHT_W +: whss_pkg::WEIGHT_W];
        end
    end

    assign mem_we    = (r_state == S_FILL) && (r_wleft != '0)
                       && (r_count < CNT_W'(TABLE_DEPTH));
    assign mem_waddr = r_count[IDX_W-1:0];
    assign mem_wdata = NUM_SOCKETS'(1) << r_sock[SOCK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_weights <= whss_pkg::WEIGHTS_RESET;
            r_cached  <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) r_weights <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_elig   <= i_eligible_mask;
                        r_h1     <= i_hash;
                        r_h2     <= i_hash2;
                        r_dbl    <= (i_mode == whss_pkg::MODE_DOUBLE);
                        r_second <= 1'b0;
                        r_bcast  <= !(i_mode == whss_pkg::MODE_SINGLE
                                      || i_mode == whss_pkg::MODE_DOUBLE);
                        if (!(i_mode == whss_pkg::MODE_SINGLE
                              || i_mode == whss_pkg::MODE_DOUBLE)) begin
                            r_res   <= i_eligible_mask;
                            r_state <= S_OUT;
                        end else begin
                            r_res <= '0;
                            if (i_eligible_mask != r_cached) begin
                                r_cached <= i_eligible_mask;
                                r_count  <= '0;
                                r_sock   <= '0;
                                r_state  <= S_SOCK;
                            end else begin
                                r_state <= S_FOLD;
                            end
                        end
                    end
                end
                S_SOCK: begin
                    if (r_sock >= SCNT_W'(NUM_SOCKETS)) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_wleft <= r_elig[r_sock[SOCK_W-1:0]] ? cur_w : '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_wleft == '0 || r_count >= CNT_W'(TABLE_DEPTH)) begin
                        r_sock  <= r_sock + 1'b1;
                        r_state <= S_SOCK;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_wleft <= r_wleft - 1'b1;
                    end
                end
                S_FOLD: begin
                    if (r_count == '0) begin
                        r_state <= S_OUT;
                    end else if (is_pow2) begin
                        r_idx   <= mixed[IDX_W-1:0] & cnt_m1[IDX_W-1:0];
                        r_state <= S_READ;
                    end else if (!is_small && r_low < cnt_ext) begin
                        r_idx   <= r_low[IDX_W-1:0];
                        r_state <= S_READ;
                    end else begin
                        // bit-serial restoring modulo
                        r_a     <= mixed;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_a <= {r_a[30:0], 1'b0};
                    if (trial >= cnt_ext) r_rem <= CNT_W'(trial - cnt_ext);
                    else                  r_rem <= trial[CNT_W-1:0];
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 6'd31) r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // remainder is final here
                    r_idx   <= r_rem[IDX_W-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_OUT;
                    r_bcast <= 1'b0;
                end
                S_OUT: begin
                    if (!r_bcast && r_count != '0) begin
                        r_res <= r_res | r_rdata;
                    end
                    if (r_dbl && !r_second && r_count != '0) begin
                        r_second <= 1'b1;
                        r_state  <= S_FOLD;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result of the last read is merged as the item leaves
    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_steer_mask = r_res;

endmodule

/* sim/tb.sv */
// testbench for weighted_hash_socket_steering: directed and random items, self-checking
// depends on whss_pkg and the block's top level; predicts each socket mask in-line
`timescale 1ns / 100ps

module tb;

    localparam int NSOCK = 8;
    localparam int DEPTH = 128;
    localparam int WATCHDOG_LIMIT = 20000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [31:0]      i_cfg_wdata;
    logic             i_start;
    logic             o_busy;
    logic [NSOCK-1:0] i_eligible_mask;
    logic [31:0]      i_hash;
    logic [31:0]      i_hash2;
    logic [1:0]       i_mode;
    logic             o_done;
    logic [NSOCK-1:0] o_steer_mask;

    // predictor state
    logic [31:0]      weights_q;
    logic [7:0]       table_mask_q;
    int unsigned      table_len_q;
    logic [7:0]       steer_table[DEPTH];

    logic [7:0]       expected_masks[$];
    int               mismatch_count;
    int               idle_cycles = 0;
    bit               timed_out = 1'b0;

    weighted_hash_socket_steering u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_eligible_mask(i_eligible_mask),
        .i_hash         (i_hash),
        .i_hash2        (i_hash2),
        .i_mode         (i_mode),
        .o_done         (o_done),
        .o_steer_mask   (o_steer_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fold_hash(logic [31:0] h);
        return h ^ (h >> 8) ^ (h >> 16) ^ (h >> 24);
    endfunction

    function automatic int unsigned table_index(logic [31:0] a, int unsigned b);
        int unsigned p;
        int unsigned r;
        if (b <= 1) return 0;
        if ((b & (b - 1)) == 0) return a & (b - 1);
        if (b == 3 || b == 5 || b == 6 || b == 7) return a % b;
        p = 1;
        while (p < b) p = p << 1;
        r = a & (p - 1);
        return (r < b) ? r : a % b;
    endfunction

    function automatic void refill_table(logic [7:0] elig);
        int unsigned w;
        table_mask_q = elig;
        table_len_q = 0;
        for (int s = 0; s < NSOCK; s++) begin
            if (elig[s]) begin
                w = (weights_q >> (4 * s)) & 4'hf;
                for (int k = 0; k < w; k++) begin
                    if (table_len_q < DEPTH) begin
                        steer_table[table_len_q] = 8'(1 << s);
                        table_len_q++;
                    end
                end
            end
        end
    endfunction

    function automatic logic [7:0] predict_mask(logic [7:0] elig, logic [31:0] h1,
                                                logic [31:0] h2, logic [1:0] mode);
        logic [7:0] res;
        res = 8'h00;
        if (mode == whss_pkg::MODE_SINGLE || mode == whss_pkg::MODE_DOUBLE) begin
            if (elig != table_mask_q) refill_table(elig);
            if (table_len_q != 0) begin
                res = steer_table[table_index(fold_hash(h1), table_len_q)];
                if (mode == whss_pkg::MODE_DOUBLE)
                    res |= steer_table[table_index(fold_hash(h2), table_len_q)];
            end
        end else begin
            res = elig;
        end
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_masks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: actual %02h", o_steer_mask);
            end else begin
                automatic logic [7:0] exp_mask = expected_masks.pop_front();
                if (o_steer_mask !== exp_mask) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("steer_mask mismatch: expected %02h actual %02h",
                                 exp_mask, o_steer_mask);
                end
            end
        end
    end

    // watchdog: cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("weighted_hash_socket_steering regression: fail");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(logic [7:0] elig, logic [31:0] h1, logic [31:0] h2,
                             logic [1:0] mode);
        i_start         <= 1'b1;
        i_eligible_mask <= elig;
        i_hash          <= h1;
        i_hash2         <= h2;
        i_mode          <= mode;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_masks.push_back(predict_mask(elig, h1, h2, mode));
        i_start <= 1'b0;
        // the block is busy for at least this cycle anyway
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_masks.size() != 0) @(posedge i_clk);
        // a rebuild plus two divides is the longest tail
        repeat (NSOCK + DEPTH + 80) @(posedge i_clk);
    endtask

    task automatic write_weights(logic [31:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        weights_q = value;
    endtask

    task automatic test_directed();
        send_item(8'h00, 32'h0, 32'h0, whss_pkg::MODE_BCAST);
        send_item(8'hff, 32'hffff_ffff, 32'hffff_ffff, whss_pkg::MODE_BCAST);
        send_item(8'ha5, 32'h1234_5678, 32'h0, whss_pkg::MODE_RSVD);
        send_item(8'h00, 32'h0, 32'h0, whss_pkg::MODE_SINGLE);        // empty table
        send_item(8'hff, 32'h0, 32'hffff_ffff, whss_pkg::MODE_SINGLE);
        send_item(8'hff, 32'hffff_ffff, 32'h8000_0001, whss_pkg::MODE_DOUBLE);
        send_item(8'h01, 32'hdead_beef, 32'h0, whss_pkg::MODE_SINGLE);
        send_item(8'h07, 32'hcafe_f00d, 32'h5555_aaaa, whss_pkg::MODE_DOUBLE);
        send_item(8'h07, 32'h0000_0000, 32'h0, whss_pkg::MODE_RSVD);  // cache must stay
        send_item(8'h07, 32'h0123_4567, 32'h89ab_cdef, whss_pkg::MODE_DOUBLE);
        send_item(8'h1f, 32'h7fff_ffff, 32'haaaa_5555, whss_pkg::MODE_DOUBLE);
        send_item(8'h3f, 32'h0f0f_0f0f, 32'hf0f0_f0f0, whss_pkg::MODE_SINGLE);
        send_item(8'h7f, 32'h3333_cccc, 32'hcccc_3333, whss_pkg::MODE_DOUBLE);
        write_weights(32'hffff_ffff);                         // 120 entries
        send_item(8'hff, 32'hffff_ffff, 32'h0000_007f, whss_pkg::MODE_DOUBLE);
        send_item(8'h80, 32'h1357_9bdf, 32'h0, whss_pkg::MODE_SINGLE);
        write_weights(32'h0000_0000);                         // all weights zero
        send_item(8'hfe, 32'h2468_ace0, 32'h1, whss_pkg::MODE_DOUBLE);
        write_weights(32'h0f00_f00f);
        send_item(8'hff, 32'h9999_6666, 32'h6666_9999, whss_pkg::MODE_DOUBLE);
        send_item(8'h90, 32'hffff_0000, 32'h0000_ffff, whss_pkg::MODE_SINGLE);
    endtask

    task automatic test_random(int count);
        logic [7:0] elig;
        logic [7:0] recent;
        recent = 8'(($urandom));
        for (int i = 0; i < count; i++) begin
            // mostly reuse a recent mask so steering hits the cached table
            elig = ($urandom_range(0, 3) == 0) ? 8'($urandom) : recent;
            recent = elig;
            send_item(elig, $urandom, $urandom, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0) idle_gap();
        end
    endtask

    task automatic test_weight_sweep();
        write_weights(32'h1111_1111);
        test_random(60);
        write_weights($urandom);
        test_random(120);
        write_weights(32'h7353_2131);
        test_random(100);
        drain();                                              // sender waits for all results
        write_weights($urandom | 32'h8888_8888);
        test_random(100);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 32'h0;
        i_start         <= 1'b0;
        i_eligible_mask <= '0;
        i_hash          <= 32'h0;
        i_hash2         <= 32'h0;
        i_mode          <= whss_pkg::MODE_BCAST;
        weights_q       = whss_pkg::WEIGHTS_RESET;
        table_mask_q    = 8'h00;
        table_len_q     = 0;
        for (int k = 0; k < DEPTH; k++) steer_table[k] = 8'h00;
        mismatch_count  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_weight_sweep();
        drain();

        if (mismatch_count == 0 && expected_masks.size() == 0) begin
            $display("weighted_hash_socket_steering regression: pass");
        end else begin
            $display("weighted_hash_socket_steering regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/whss_pkg.sv
design/weighted_hash_socket_steering.sv
sim/tb.sv
